### rtl/pdrf_pkg.sv
package pdrf_pkg;

   localparam int MAX_REFS  = 8;
   localparam int MAX_LEN   = 65536;
   localparam int NUM_PAIRS = (MAX_REFS * (MAX_REFS - 1)) / 2;
   localparam int LANE_W    = $clog2(MAX_REFS);
   localparam int PAIR_W    = $clog2(NUM_PAIRS);
   localparam int LEN_W     = $clog2(MAX_LEN) + 1;
   localparam int CHAR_W    = 8;
   localparam int NREF_W    = 4;
   localparam int HP_W      = 7;
   localparam int LPM_W     = 10;
   localparam int MINK_W    = 4;
   localparam int CSR_W     = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int HI_PROD_W = HP_W + LEN_W;
   localparam int LO_PROD_W = LPM_W + LEN_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_REFS      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_PERCENT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_PER_MILLE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_KEPT      = 2'd3;

   localparam logic [NREF_W-1:0] NUM_REFS_RESET      = 4'd8;
   localparam logic [HP_W-1:0]   HIGH_PERCENT_RESET  = 7'd20;
   localparam logic [LPM_W-1:0]  LOW_PER_MILLE_RESET = 10'd5;
   localparam logic [MINK_W-1:0] MIN_KEPT_RESET      = 4'd3;

   localparam logic [LANE_W-1:0] PAIR_HI [0:NUM_PAIRS-1] = '{
      3'd1,
      3'd2, 3'd2,
      3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
      3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
   };

   localparam logic [LANE_W-1:0] PAIR_LO [0:NUM_PAIRS-1] = '{
      3'd0,
      3'd0, 3'd1,
      3'd0, 3'd1, 3'd2,
      3'd0, 3'd1, 3'd2, 3'd3,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
   };

   typedef struct packed {
      logic [CHAR_W-1:0] char_0;
      logic [CHAR_W-1:0] char_1;
      logic [CHAR_W-1:0] char_2;
      logic [CHAR_W-1:0] char_3;
      logic [CHAR_W-1:0] char_4;
      logic [CHAR_W-1:0] char_5;
      logic [CHAR_W-1:0] char_6;
      logic [CHAR_W-1:0] char_7;
      logic              last_column;
   } req_type;

   typedef struct packed {
      logic [MAX_REFS-1:0] keep_mask;
      logic [NREF_W-1:0]   kept_count;
      logic                too_few;
      logic [LEN_W-1:0]    column_total;
   } rsp_type;

   typedef struct packed {
      logic count;
      logic prep;
      logic eval;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic eval_last;
      logic out_free;
   } status_type;

endpackage

### rtl/pdrf_ctrl.sv
module pdrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  pdrf_pkg::status_type status,
   output pdrf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_COUNT  = 4'b0001,
      ST_PREP   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_COUNT: begin
            req_ready = 1'b1;
            cmd.count = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.eval_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_COUNT;
            end
         end
         default: begin
            state_in = ST_COUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/pdrf_dp.sv
module pdrf_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  pdrf_pkg::cmd_type                 cmd,
   output pdrf_pkg::status_type              status,
   input  pdrf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pdrf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [pdrf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pdrf_pkg::CSR_W-1:0]        csr_wdata
);

   logic [pdrf_pkg::NREF_W-1:0] num_refs_ff;
   logic [pdrf_pkg::HP_W-1:0]   high_percent_ff;
   logic [pdrf_pkg::LPM_W-1:0]  low_per_mille_ff;
   logic [pdrf_pkg::MINK_W-1:0] min_kept_ff;

   logic [pdrf_pkg::CHAR_W-1:0] lane [pdrf_pkg::MAX_REFS];

   logic [pdrf_pkg::LEN_W-1:0] pair_cnt_ff [pdrf_pkg::NUM_PAIRS];
   logic [pdrf_pkg::LEN_W-1:0] pair_cnt_in [pdrf_pkg::NUM_PAIRS];
   logic [pdrf_pkg::LEN_W-1:0] cols_ff;
   logic [pdrf_pkg::LEN_W-1:0] cols_in;

   logic [pdrf_pkg::PAIR_W-1:0]    pair_idx_ff;
   logic [pdrf_pkg::PAIR_W-1:0]    pair_idx_in;
   logic [pdrf_pkg::MAX_REFS-1:0]  removed_ff;
   logic [pdrf_pkg::MAX_REFS-1:0]  removed_in;
   logic [pdrf_pkg::HI_PROD_W-1:0] hi_prod_ff;
   logic [pdrf_pkg::HI_PROD_W-1:0] hi_prod_in;
   logic [pdrf_pkg::LO_PROD_W-1:0] lo_prod_ff;
   logic [pdrf_pkg::LO_PROD_W-1:0] lo_prod_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   pdrf_pkg::rsp_type     rsp_data_ff;
   pdrf_pkg::rsp_type     rsp_data_in;

   logic [pdrf_pkg::NREF_W-1:0]    num_eff;
   logic [pdrf_pkg::LEN_W-1:0]     pair_dist;
   logic [pdrf_pkg::LANE_W-1:0]    cur_hi;
   logic [pdrf_pkg::LANE_W-1:0]    cur_lo;
   logic [pdrf_pkg::HI_PROD_W-1:0] dist_x100;
   logic [pdrf_pkg::LO_PROD_W-1:0] dist_x1000;
   logic                           pair_fail;
   logic [pdrf_pkg::MAX_REFS-1:0]  mask_all;
   logic [pdrf_pkg::MAX_REFS-1:0]  survivors;
   logic [pdrf_pkg::NREF_W-1:0]    kept;

   assign lane[0] = req_data.char_0;
   assign lane[1] = req_data.char_1;
   assign lane[2] = req_data.char_2;
   assign lane[3] = req_data.char_3;
   assign lane[4] = req_data.char_4;
   assign lane[5] = req_data.char_5;
   assign lane[6] = req_data.char_6;
   assign lane[7] = req_data.char_7;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_refs_ff      <= pdrf_pkg::NUM_REFS_RESET;
         high_percent_ff  <= pdrf_pkg::HIGH_PERCENT_RESET;
         low_per_mille_ff <= pdrf_pkg::LOW_PER_MILLE_RESET;
         min_kept_ff      <= pdrf_pkg::MIN_KEPT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            pdrf_pkg::CSR_NUM_REFS:      num_refs_ff      <= csr_wdata[pdrf_pkg::NREF_W-1:0];
            pdrf_pkg::CSR_HIGH_PERCENT:  high_percent_ff  <= csr_wdata[pdrf_pkg::HP_W-1:0];
            pdrf_pkg::CSR_LOW_PER_MILLE: low_per_mille_ff <= csr_wdata[pdrf_pkg::LPM_W-1:0];
            pdrf_pkg::CSR_MIN_KEPT:      min_kept_ff      <= csr_wdata[pdrf_pkg::MINK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // count one column, saturate at full length, clear once a result is out
   always_comb begin
      for (int k = 0; k < pdrf_pkg::NUM_PAIRS; k++) begin
         pair_cnt_in[k] = pair_cnt_ff[k];
         if (cmd.finish) begin
            pair_cnt_in[k] = '0;
         end else if (cmd.count
                      && lane[pdrf_pkg::PAIR_HI[k]] != lane[pdrf_pkg::PAIR_LO[k]]
                      && pair_cnt_ff[k] < pdrf_pkg::LEN_W'(pdrf_pkg::MAX_LEN)) begin
            pair_cnt_in[k] = pair_cnt_ff[k] + 1'b1;
         end
      end
      cols_in = cols_ff;
      if (cmd.finish) begin
         cols_in = '0;
      end else if (cmd.count && cols_ff < pdrf_pkg::LEN_W'(pdrf_pkg::MAX_LEN)) begin
         cols_in = cols_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pdrf_pkg::NUM_PAIRS; k++) begin
            pair_cnt_ff[k] <= '0;
         end
         cols_ff <= '0;
      end else begin
         pair_cnt_ff <= pair_cnt_in;
         cols_ff     <= cols_in;
      end
   end

   // d > floor(hp*L/100) holds exactly when hp*L < 100*d
   assign num_eff    = (num_refs_ff > pdrf_pkg::NREF_W'(pdrf_pkg::MAX_REFS))
                       ? pdrf_pkg::NREF_W'(pdrf_pkg::MAX_REFS) : num_refs_ff;
   assign pair_dist  = pair_cnt_ff[pair_idx_ff];
   assign cur_hi     = pdrf_pkg::PAIR_HI[pair_idx_ff];
   assign cur_lo     = pdrf_pkg::PAIR_LO[pair_idx_ff];
   assign dist_x100  = pdrf_pkg::HI_PROD_W'(pair_dist) * pdrf_pkg::HI_PROD_W'(100);
   assign dist_x1000 = pdrf_pkg::LO_PROD_W'(pair_dist) * pdrf_pkg::LO_PROD_W'(1000);
   assign pair_fail  = (pdrf_pkg::NREF_W'(cur_hi) < num_eff)
                       && ((hi_prod_ff < dist_x100) || (dist_x1000 < lo_prod_ff));

   always_comb begin
      pair_idx_in = pair_idx_ff;
      removed_in  = removed_ff;
      hi_prod_in  = hi_prod_ff;
      lo_prod_in  = lo_prod_ff;
      if (cmd.prep) begin
         pair_idx_in = '0;
         removed_in  = '0;
         hi_prod_in  = pdrf_pkg::HI_PROD_W'(high_percent_ff) * pdrf_pkg::HI_PROD_W'(cols_ff);
         lo_prod_in  = pdrf_pkg::LO_PROD_W'(low_per_mille_ff) * pdrf_pkg::LO_PROD_W'(cols_ff);
      end else if (cmd.eval) begin
         pair_idx_in = pair_idx_ff + 1'b1;
         if (pair_fail) begin
            removed_in[cur_hi] = 1'b1;
            removed_in[cur_lo] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_idx_ff <= '0;
      end else begin
         pair_idx_ff <= pair_idx_in;
      end
      removed_ff <= removed_in;
      hi_prod_ff <= hi_prod_in;
      lo_prod_ff <= lo_prod_in;
   end

   always_comb begin
      kept = '0;
      for (int i = 0; i < pdrf_pkg::MAX_REFS; i++) begin
         mask_all[i] = (pdrf_pkg::NREF_W'(i) < num_eff);
      end
      survivors = mask_all & ~removed_ff;
      for (int i = 0; i < pdrf_pkg::MAX_REFS; i++) begin
         kept = kept + pdrf_pkg::NREF_W'(survivors[i]);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.too_few      = (kept < min_kept_ff);
         rsp_data_in.keep_mask    = (kept < min_kept_ff) ? mask_all : survivors;
         rsp_data_in.kept_count   = kept;
         rsp_data_in.column_total = cols_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign status.eval_last = (pair_idx_ff == pdrf_pkg::PAIR_W'(pdrf_pkg::NUM_PAIRS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

### rtl/pairwise_distance_reference_filter.sv
// Columns: one item per cycle while req_ready is high; every pair counter updates
// in the same cycle. Last column: req_ready drops while the limit products are
// formed, the 28 pair counters are walked one pair a cycle through a shared
// compare, and the result is loaded. rsp_valid rises with that load, which waits
// only while the previous item still sits unaccepted in the output register.
// Reset (synchronous): registers to defaults, all counters clear, no item pending.
module pairwise_distance_reference_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pdrf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pdrf_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [pdrf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [pdrf_pkg::CSR_W-1:0]       csr_wdata
);

   pdrf_pkg::cmd_type    cmd;
   pdrf_pkg::status_type status;

   pdrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_column),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdrf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   a_last_stalls_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_column |=> !req_ready)
      else $error("input taken right after a last column");

   a_result_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an evaluation pass");

   a_mask_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.too_few |->
         $countones(rsp_data.keep_mask) == int'(rsp_data.kept_count))
      else $error("keep mask disagrees with kept count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kept_count <= 4'd8)
      else $error("kept count out of range");

endmodule
